### rtl/srtlpm_pkg.sv
`timescale 1ns / 1ps
// Package for the sorted route table with longest prefix match.
// Holds the field widths, operation and status codes, and the shared structs.
package srtlpm_pkg;

  // Default sizes, handed to the top level as parameter defaults.
  localparam int unsigned TABLE_DEPTH_DEF = 64;
  localparam int unsigned ADDR_WIDTH_DEF  = 48;

  // Fixed field widths.
  localparam int unsigned OP_W     = 2;
  localparam int unsigned PLEN_W   = 6;
  localparam int unsigned COST_W   = 16;
  localparam int unsigned PORT_W   = 8;
  localparam int unsigned HOP_W    = 48;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned TOTAL_W  = 7;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  // Sequencer states: take a beat, compare in every cell, resolve the first
  // matching cell, then update the table and write the result.
  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_SCAN,
    S_APPLY
  } state_e;

  // Route fields other than the destination, whose width is a parameter.
  typedef struct packed {
    logic [PLEN_W-1:0] prefix;
    logic [COST_W-1:0] cost;
    logic [PORT_W-1:0] port;
    logic [HOP_W-1:0]  hop;
  } route_attr_t;

  // Operation broadcast to all cells.
  typedef struct packed {
    logic [OP_W-1:0] op;
    route_attr_t     attr;
  } cmd_t;

  // Phase enables from the sequencer to the cells.
  typedef struct packed {
    logic flag_en;
    logic scan_en;
    logic apply_en;
  } cell_ctrl_t;

endpackage

### rtl/srtlpm_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces of the route table.
// Depends on srtlpm_pkg for the field widths.
interface srtlpm_req_if #(
  parameter int unsigned ADDR_WIDTH = srtlpm_pkg::ADDR_WIDTH_DEF
);
  logic                            valid;
  logic                            ready;
  logic [srtlpm_pkg::OP_W-1:0]     opcode;
  logic [ADDR_WIDTH-1:0]           address;
  logic [srtlpm_pkg::PLEN_W-1:0]   prefix_len;
  logic [srtlpm_pkg::COST_W-1:0]   metric;
  logic [srtlpm_pkg::PORT_W-1:0]   iface;
  logic [srtlpm_pkg::HOP_W-1:0]    next_hop;

  modport source (
    output valid, opcode, address, prefix_len, metric, iface, next_hop,
    input  ready
  );
  modport sink (
    input  valid, opcode, address, prefix_len, metric, iface, next_hop,
    output ready
  );
endinterface

interface srtlpm_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [srtlpm_pkg::STATUS_W-1:0] status;
  logic [srtlpm_pkg::PORT_W-1:0]   out_iface;
  logic [srtlpm_pkg::HOP_W-1:0]    out_next_hop;
  logic [srtlpm_pkg::TOTAL_W-1:0]  route_total;

  modport source (
    output valid, status, out_iface, out_next_hop, route_total,
    input  ready
  );
  modport sink (
    input  valid, status, out_iface, out_next_hop, route_total,
    output ready
  );
endinterface

### rtl/srtlpm_cell.sv
`timescale 1ns / 1ps
// One table slot: holds a route, compares it with the current operation and
// shifts to or from its neighbors. Depends on srtlpm_pkg.
module srtlpm_cell #(
  parameter int unsigned ADDR_WIDTH = srtlpm_pkg::ADDR_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  srtlpm_pkg::cell_ctrl_t        ctrl_i,
  input  srtlpm_pkg::cmd_t              cmd_i,
  input  logic [ADDR_WIDTH-1:0]         cmd_dest_i,
  input  logic                          valid_i,
  output logic                          flag_o,
  input  logic                          scan_i,
  output logic                          scan_o,
  input  logic                          prev_scan_i,
  input  logic [ADDR_WIDTH-1:0]         prev_dest_i,
  input  srtlpm_pkg::route_attr_t       prev_attr_i,
  input  logic [ADDR_WIDTH-1:0]         next_dest_i,
  input  srtlpm_pkg::route_attr_t       next_attr_i,
  output logic [ADDR_WIDTH-1:0]         dest_o,
  output srtlpm_pkg::route_attr_t       attr_o,
  output logic [srtlpm_pkg::PORT_W-1:0] hit_port_o,
  output logic [srtlpm_pkg::HOP_W-1:0]  hit_hop_o
);
  import srtlpm_pkg::*;

  logic [ADDR_WIDTH-1:0] dest_q;
  route_attr_t           attr_q;
  logic                  flag_q;
  logic                  scan_q;
  logic [ADDR_WIDTH-1:0] mask;
  logic                  prefix_hit;
  logic                  sorts_before;
  logic                  exact_hit;
  logic                  flag_d;
  logic                  first;

  // Prefix mask of the stored route: its top prefix bits set.
  assign mask       = ~({ADDR_WIDTH{1'b1}} >> attr_q.prefix);
  assign prefix_hit = ((cmd_dest_i ^ dest_q) & mask) == '0;
  assign exact_hit  = (cmd_dest_i == dest_q) && (cmd_i.attr == attr_q);

  // New route orders strictly ahead of this slot.
  always_comb begin
    if (cmd_i.attr.prefix != attr_q.prefix) begin
      sorts_before = cmd_i.attr.prefix > attr_q.prefix;
    end else if (cmd_dest_i != dest_q) begin
      sorts_before = cmd_dest_i < dest_q;
    end else begin
      sorts_before = cmd_i.attr.cost < attr_q.cost;
    end
  end

  // Per-operation match flag. Empty slots count as behind any new route.
  always_comb begin
    case (cmd_i.op)
      OP_LOOKUP: flag_d = valid_i & prefix_hit;
      OP_ADD:    flag_d = ~valid_i | sorts_before;
      OP_REMOVE: flag_d = valid_i & exact_hit;
      default:   flag_d = 1'b0;
    endcase
  end

  // Flag and scan result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
      scan_q <= 1'b0;
    end else begin
      if (ctrl_i.flag_en) begin
        flag_q <= flag_d;
      end
      if (ctrl_i.scan_en) begin
        scan_q <= scan_i;
      end
    end
  end

  // This slot holds the first match in table order.
  assign first = scan_q & ~prev_scan_i;

  // Insert opens a gap by shifting down; remove closes one by shifting up.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.apply_en) begin
      case (cmd_i.op)
        OP_ADD: begin
          if (first) begin
            dest_q <= cmd_dest_i;
            attr_q <= cmd_i.attr;
          end else if (prev_scan_i) begin
            dest_q <= prev_dest_i;
            attr_q <= prev_attr_i;
          end
        end
        OP_REMOVE: begin
          if (scan_q) begin
            dest_q <= next_dest_i;
            attr_q <= next_attr_i;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign flag_o     = flag_q;
  assign scan_o     = scan_q;
  assign dest_o     = dest_q;
  assign attr_o     = attr_q;
  assign hit_port_o = first ? attr_q.port : '0;
  assign hit_hop_o  = first ? attr_q.hop : '0;

endmodule

### rtl/srtlpm_scan.sv
`timescale 1ns / 1ps
// Prefix OR over the cell flags: output bit i is set when any flag at or
// before slot i is set. Depends on srtlpm_pkg.
module srtlpm_scan #(
  parameter int unsigned TABLE_DEPTH = srtlpm_pkg::TABLE_DEPTH_DEF
) (
  input  logic [TABLE_DEPTH-1:0] flag_i,
  output logic [TABLE_DEPTH-1:0] scan_o
);
  import srtlpm_pkg::*;

  localparam int unsigned LEVELS = $clog2(TABLE_DEPTH);

  logic [TABLE_DEPTH-1:0] lvl [LEVELS+1];

  // Log-depth parallel prefix network.
  always_comb begin
    lvl[0] = flag_i;
    for (int l = 0; l < LEVELS; l++) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (i >= (1 << l)) begin
          lvl[l+1][i] = lvl[l][i] | lvl[l][i-(1<<l)];
        end else begin
          lvl[l+1][i] = lvl[l][i];
        end
      end
    end
  end

  assign scan_o = lvl[LEVELS];

endmodule

### rtl/sorted_route_table_lpm_unit.sv
`timescale 1ns / 1ps
// Top level of the sorted route table with longest prefix match.
// Depends on srtlpm_pkg, srtlpm_if, srtlpm_cell and srtlpm_scan.
//
// One request beat carries one operation: lookup, add route or remove route.
// Each request gives exactly one response beat with a status, the matched
// interface and next hop for a found lookup, and the route count afterwards.
// The table is a row of cells, one route each, kept in sorted order: longer
// prefix first, then lower destination, then lower metric.
// An operation passes four steps from one accept to the next: the beat is
// latched, all cells compare in parallel, the prefix OR network finds the
// first matching cell, and the cells shift to insert or delete while the
// response register loads.
// A response waiting on the output register does not block the next request;
// the block only holds in its final step while the previous response is
// still unread, so a stalled receiver stalls the table update, never drops it.
// Reset empties the table at once by clearing the route count; no clearing
// pass runs and requests are accepted in the first cycle after reset.
module sorted_route_table_lpm_unit #(
  parameter int unsigned TABLE_DEPTH = srtlpm_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned ADDR_WIDTH  = srtlpm_pkg::ADDR_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  srtlpm_req_if.sink        req_i,
  srtlpm_rsp_if.source      rsp_o
);
  import srtlpm_pkg::*;

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned PW1   = PLEN_W + 1;

  state_e                 state_q, state_d;
  cell_ctrl_t             ctrl;
  logic                   out_free;
  logic                   in_ready;

  cmd_t                   cmd_q;
  logic [ADDR_WIDTH-1:0]  cmd_dest_q;
  logic [PLEN_W-1:0]      plen_sat;
  logic [CNT_W-1:0]       count_q;
  logic                   full;

  logic [TABLE_DEPTH-1:0] flags;
  logic [TABLE_DEPTH-1:0] scan_d;
  logic [TABLE_DEPTH-1:0] scan_q;
  logic [TABLE_DEPTH-1:0] cell_valid;
  logic [ADDR_WIDTH-1:0]  dest_v [TABLE_DEPTH];
  route_attr_t            attr_v [TABLE_DEPTH];
  logic [PORT_W-1:0]      hit_port_v [TABLE_DEPTH];
  logic [HOP_W-1:0]       hit_hop_v [TABLE_DEPTH];

  logic [PORT_W-1:0]      rd_port;
  logic [HOP_W-1:0]       rd_hop;
  logic                   found;

  logic                   out_valid_q;
  status_e                status_q;
  logic [PORT_W-1:0]      out_port_q;
  logic [HOP_W-1:0]       out_hop_q;
  logic [CNT_W-1:0]       count_d;
  status_e                status_d;

  // Sequencer state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign out_free = ~out_valid_q | rsp_o.ready;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (req_i.valid) state_d = S_CMP;
      S_CMP:   state_d = S_SCAN;
      S_SCAN:  state_d = S_APPLY;
      S_APPLY: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready      = 1'b0;
    ctrl.flag_en  = 1'b0;
    ctrl.scan_en  = 1'b0;
    ctrl.apply_en = 1'b0;
    case (state_q)
      S_IDLE:  in_ready = 1'b1;
      S_CMP:   ctrl.flag_en = 1'b1;
      S_SCAN:  ctrl.scan_en = 1'b1;
      S_APPLY: ctrl.apply_en = out_free & ~((cmd_q.op == OP_ADD) & full);
      default: ;
    endcase
  end

  assign req_i.ready = in_ready;

  // Latch the request; the prefix length saturates at the address width.
  assign plen_sat = ({1'b0, req_i.prefix_len} > PW1'(ADDR_WIDTH)) ?
                    PLEN_W'(ADDR_WIDTH) : req_i.prefix_len;

  always_ff @(posedge clk_i) begin
    if (req_i.valid && in_ready) begin
      cmd_q.op          <= req_i.opcode;
      cmd_q.attr.prefix <= plen_sat;
      cmd_q.attr.cost   <= req_i.metric;
      cmd_q.attr.port   <= req_i.iface;
      cmd_q.attr.hop    <= req_i.next_hop;
      cmd_dest_q        <= req_i.address;
    end
  end

  assign full = count_q == CNT_W'(TABLE_DEPTH);

  // Row of cells, each wired to its neighbors.
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    logic                  prev_scan;
    logic [ADDR_WIDTH-1:0] prev_dest;
    route_attr_t           prev_attr;
    logic [ADDR_WIDTH-1:0] next_dest;
    route_attr_t           next_attr;

    assign cell_valid[g] = count_q > CNT_W'(g);

    if (g == 0) begin : g_head
      assign prev_scan = 1'b0;
      assign prev_dest = cmd_dest_q;
      assign prev_attr = cmd_q.attr;
    end else begin : g_body
      assign prev_scan = scan_q[g-1];
      assign prev_dest = dest_v[g-1];
      assign prev_attr = attr_v[g-1];
    end

    if (g == TABLE_DEPTH - 1) begin : g_tail
      assign next_dest = '0;
      assign next_attr = '0;
    end else begin : g_mid
      assign next_dest = dest_v[g+1];
      assign next_attr = attr_v[g+1];
    end

    srtlpm_cell #(
      .ADDR_WIDTH (ADDR_WIDTH)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .cmd_i       (cmd_q),
      .cmd_dest_i  (cmd_dest_q),
      .valid_i     (cell_valid[g]),
      .flag_o      (flags[g]),
      .scan_i      (scan_d[g]),
      .scan_o      (scan_q[g]),
      .prev_scan_i (prev_scan),
      .prev_dest_i (prev_dest),
      .prev_attr_i (prev_attr),
      .next_dest_i (next_dest),
      .next_attr_i (next_attr),
      .dest_o      (dest_v[g]),
      .attr_o      (attr_v[g]),
      .hit_port_o  (hit_port_v[g]),
      .hit_hop_o   (hit_hop_v[g])
    );
  end

  // First-match resolution over the registered flags.
  srtlpm_scan #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_scan (
    .flag_i (flags),
    .scan_o (scan_d)
  );

  // Only the first matching cell drives nonzero read data.
  always_comb begin
    rd_port = '0;
    rd_hop  = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      rd_port = rd_port | hit_port_v[i];
      rd_hop  = rd_hop | hit_hop_v[i];
    end
  end

  assign found = scan_q[TABLE_DEPTH-1];

  // Result status and new route count.
  always_comb begin
    count_d  = count_q;
    status_d = ST_MISS;
    case (cmd_q.op)
      OP_LOOKUP: status_d = found ? ST_OK : ST_MISS;
      OP_ADD: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          status_d = ST_OK;
          count_d  = count_q + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (found) begin
          status_d = ST_OK;
          count_d  = count_q - CNT_W'(1);
        end
      end
      default: status_d = ST_MISS;
    endcase
  end

  // Route count and response valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else if ((state_q == S_APPLY) && out_free) begin
      count_q     <= count_d;
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Response payload register.
  always_ff @(posedge clk_i) begin
    if ((state_q == S_APPLY) && out_free) begin
      status_q <= status_d;
      if ((cmd_q.op == OP_LOOKUP) && found) begin
        out_port_q <= rd_port;
        out_hop_q  <= rd_hop;
      end else begin
        out_port_q <= '0;
        out_hop_q  <= '0;
      end
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = status_q;
  assign rsp_o.out_iface    = out_port_q;
  assign rsp_o.out_next_hop = out_hop_q;
  assign rsp_o.route_total  = TOTAL_W'(count_q);

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for sorted_route_table_lpm_unit.
// Depends on srtlpm_pkg, srtlpm_if and the RTL of the route table.
module tb_top;
  import srtlpm_pkg::*;

  localparam int unsigned TBL_DEPTH  = TABLE_DEPTH_DEF;
  localparam int unsigned ADDR_W     = ADDR_WIDTH_DEF;
  localparam int unsigned RAND_ITEMS = 1700;
  localparam int unsigned IDLE_PCT   = 18;
  localparam int unsigned MAX_REPORT = 10;
  localparam int unsigned TAIL_WAIT  = 16;

  // Opcode value that the block does not define.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [ADDR_W-1:0] address;
    logic [PLEN_W-1:0] prefix_len;
    logic [COST_W-1:0] metric;
    logic [PORT_W-1:0] iface;
    logic [HOP_W-1:0]  next_hop;
  } op_beat_t;

  typedef struct packed {
    status_e            status;
    logic [PORT_W-1:0]  iface;
    logic [HOP_W-1:0]   hop;
    logic [TOTAL_W-1:0] total;
  } rsp_expect_t;

  typedef struct packed {
    logic [ADDR_W-1:0] dest;
    logic [PLEN_W-1:0] prefix;
    logic [COST_W-1:0] cost;
    logic [PORT_W-1:0] port;
    logic [HOP_W-1:0]  hop;
  } route_t;

  typedef struct {
    op_beat_t    beat;
    bit          typed;
    rsp_expect_t want;
  } dir_row_t;

  localparam rsp_expect_t NO_WANT = '{ST_OK, '0, '0, '0};

  logic clk_i = 1'b0;
  logic rst_ni;

  srtlpm_req_if #(.ADDR_WIDTH(ADDR_W)) req_if ();
  srtlpm_rsp_if rsp_if ();

  sorted_route_table_lpm_unit #(
    .TABLE_DEPTH (TBL_DEPTH),
    .ADDR_WIDTH  (ADDR_W)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #10 clk_i = ~clk_i;

  // Mirror of the route table, kept in the same sorted order as the block.
  route_t      routes [TBL_DEPTH];
  int unsigned route_cnt;
  rsp_expect_t pending_results [$];
  rsp_expect_t head_want;
  bit          idle_on = 1'b1;
  int unsigned mismatch_cnt;
  int unsigned results_checked;
  int unsigned n_lookup, n_hit, n_add, n_full, n_remove, n_removed, n_unused, peak_cnt;

  function automatic bit prefix_hit(logic [ADDR_W-1:0] addr, route_t r);
    if (r.prefix == '0) return 1'b1;
    return ((addr ^ r.dest) >> (ADDR_W - r.prefix)) == '0;
  endfunction

  // True when the new route belongs strictly ahead of the held one.
  function automatic bit ranks_ahead(route_t nr, route_t held);
    if (nr.prefix != held.prefix) return nr.prefix > held.prefix;
    if (nr.dest != held.dest) return nr.dest < held.dest;
    return nr.cost < held.cost;
  endfunction

  // Apply one operation to the mirror table and return the response it gives.
  function automatic rsp_expect_t predict_route_op(op_beat_t b);
    rsp_expect_t res;
    route_t      nr;
    int unsigned pos;
    nr = '{b.address, b.prefix_len, b.metric, b.iface, b.next_hop};
    if (nr.prefix > ADDR_W) nr.prefix = PLEN_W'(ADDR_W);
    res = '{ST_MISS, '0, '0, '0};
    case (b.opcode)
      OP_LOOKUP: begin
        n_lookup++;
        for (int i = 0; i < route_cnt; i++) begin
          if (prefix_hit(b.address, routes[i])) begin
            res.status = ST_OK;
            res.iface  = routes[i].port;
            res.hop    = routes[i].hop;
            n_hit++;
            break;
          end
        end
      end
      OP_ADD: begin
        n_add++;
        if (route_cnt >= TBL_DEPTH) begin
          res.status = ST_FULL;
          n_full++;
        end else begin
          pos = route_cnt;
          for (int i = 0; i < route_cnt; i++) begin
            if (ranks_ahead(nr, routes[i])) begin
              pos = i;
              break;
            end
          end
          for (int j = route_cnt; j > pos; j--) routes[j] = routes[j-1];
          routes[pos] = nr;
          route_cnt++;
          if (route_cnt > peak_cnt) peak_cnt = route_cnt;
          res.status = ST_OK;
        end
      end
      OP_REMOVE: begin
        n_remove++;
        for (int i = 0; i < route_cnt; i++) begin
          if (routes[i] == nr) begin
            for (int j = i; j + 1 < route_cnt; j++) routes[j] = routes[j+1];
            route_cnt--;
            res.status = ST_OK;
            n_removed++;
            break;
          end
        end
      end
      default: n_unused++;
    endcase
    res.total = TOTAL_W'(route_cnt);
    return res;
  endfunction

  function automatic op_beat_t mk_beat(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                                       logic [PLEN_W-1:0] plen, logic [COST_W-1:0] metric,
                                       logic [PORT_W-1:0] iface, logic [HOP_W-1:0] hop);
    return '{op, addr, plen, metric, iface, hop};
  endfunction

  // Drive one request beat, wait for the handshake and record what it must return.
  task automatic send_op(input op_beat_t beat, input bit typed, input rsp_expect_t want);
    rsp_expect_t got;
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.opcode     <= beat.opcode;
    req_if.address    <= beat.address;
    req_if.prefix_len <= beat.prefix_len;
    req_if.metric     <= beat.metric;
    req_if.iface      <= beat.iface;
    req_if.next_hop   <= beat.next_hop;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    got = predict_route_op(beat);
    pending_results.push_back(typed ? want : got);
  endtask

  // Response side: random back-pressure except during the quiet stretch.
  always @(posedge clk_i) begin
    rsp_if.ready <= idle_on ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
  end

  // Compare each response beat with the oldest outstanding expectation.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORT)
          $display("%0t: response beat with none outstanding: st=%0d if=%0h hop=%0h tot=%0d",
                   $realtime, rsp_if.status, rsp_if.out_iface, rsp_if.out_next_hop,
                   rsp_if.route_total);
      end else begin
        head_want = pending_results.pop_front();
        results_checked++;
        if (rsp_if.status !== head_want.status || rsp_if.out_iface !== head_want.iface ||
            rsp_if.out_next_hop !== head_want.hop || rsp_if.route_total !== head_want.total)
        begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORT) begin
            $write("%0t: response %0d: expected st=%0d if=%0h hop=%0h tot=%0d, ",
                   $realtime, results_checked, head_want.status, head_want.iface,
                   head_want.hop, head_want.total);
            $display("got st=%0d if=%0h hop=%0h tot=%0d",
                     rsp_if.status, rsp_if.out_iface, rsp_if.out_next_hop,
                     rsp_if.route_total);
          end
        end
      end
    end
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    dir_row_t          dir_rows [$];
    op_beat_t          b;
    route_t            sel;
    logic [ADDR_W-1:0] base_pool [8];
    logic [ADDR_W-1:0] rnd48;
    int unsigned       kind, phase, phase_len, items_sent, r, k, pick;

    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.opcode     = '0;
    req_if.address    = '0;
    req_if.prefix_len = '0;
    req_if.metric     = '0;
    req_if.iface      = '0;
    req_if.next_hop   = '0;
    route_cnt         = 0;

    // Directed rows: empty table, extremes, saturation, ties and ordering.
    dir_rows.push_back('{mk_beat(OP_LOOKUP, '0, '0, '0, '0, '0), 1'b1,
                         '{ST_MISS, '0, '0, 7'd0}});
    dir_rows.push_back('{mk_beat(OP_REMOVE, '0, '0, '0, '0, '0), 1'b1,
                         '{ST_MISS, '0, '0, 7'd0}});
    dir_rows.push_back('{mk_beat(OP_UNUSED, '1, '1, '1, '1, '1), 1'b1,
                         '{ST_MISS, '0, '0, 7'd0}});
    dir_rows.push_back('{mk_beat(OP_ADD, '0, '0, '0, 8'hFF, '1), 1'b1,
                         '{ST_OK, '0, '0, 7'd1}});
    dir_rows.push_back('{mk_beat(OP_LOOKUP, '1, '0, '0, '0, '0), 1'b1,
                         '{ST_OK, 8'hFF, '1, 7'd1}});
    dir_rows.push_back('{mk_beat(OP_ADD, '1, 6'd48, '1, 8'h01, 48'h1), 1'b1,
                         '{ST_OK, '0, '0, 7'd2}});
    dir_rows.push_back('{mk_beat(OP_LOOKUP, '1, '1, '1, '1, '1), 1'b0, NO_WANT});
    // A prefix length past the address width is clipped to it.
    dir_rows.push_back('{mk_beat(OP_ADD, 48'h1234_5678_9ABC, 6'd63, 16'd5, 8'h11,
                                 48'h0000_0000_0011), 1'b1, '{ST_OK, '0, '0, 7'd3}});
    dir_rows.push_back('{mk_beat(OP_REMOVE, 48'h1234_5678_9ABC, 6'd48, 16'd5, 8'h11,
                                 48'h0000_0000_0011), 1'b0, NO_WANT});
    // Two equal keys: the later add lands behind the earlier one.
    dir_rows.push_back('{mk_beat(OP_ADD, 48'hABCD_0000_0000, 6'd16, 16'd10, 8'h02,
                                 48'h0000_0000_0002), 1'b0, NO_WANT});
    dir_rows.push_back('{mk_beat(OP_ADD, 48'hABCD_0000_0000, 6'd16, 16'd10, 8'h03,
                                 48'h0000_0000_0003), 1'b0, NO_WANT});
    dir_rows.push_back('{mk_beat(OP_LOOKUP, 48'hABCD_1234_5678, '0, '0, '0, '0), 1'b0, NO_WANT});
    dir_rows.push_back('{mk_beat(OP_ADD, 48'hABCD_0000_0000, 6'd16, 16'd9, 8'h04,
                                 48'h0000_0000_0004), 1'b0, NO_WANT});
    dir_rows.push_back('{mk_beat(OP_LOOKUP, 48'hABCD_8765_4321, '0, '0, '0, '0), 1'b0, NO_WANT});
    dir_rows.push_back('{mk_beat(OP_ADD, 48'hABCD_EF00_0000, 6'd24, 16'd100, 8'h05,
                                 48'h0000_0000_0005), 1'b0, NO_WANT});
    dir_rows.push_back('{mk_beat(OP_LOOKUP, 48'hABCD_EF00_0001, '0, '0, '0, '0), 1'b0, NO_WANT});
    dir_rows.push_back('{mk_beat(OP_REMOVE, 48'hABCD_0000_0000, 6'd16, 16'd9, 8'h04,
                                 48'h0000_0000_0005), 1'b1, '{ST_MISS, '0, '0, 7'd6}});
    dir_rows.push_back('{mk_beat(OP_REMOVE, 48'hABCD_0000_0000, 6'd16, 16'd9, 8'h04,
                                 48'h0000_0000_0004), 1'b0, NO_WANT});
    dir_rows.push_back('{mk_beat(OP_ADD, 48'h8000_0000_0000, 6'd1, 16'd0, 8'h80,
                                 48'h8000_0000_0000), 1'b0, NO_WANT});
    dir_rows.push_back('{mk_beat(OP_LOOKUP, 48'h7FFF_FFFF_FFFF, '1, '1, '1, '1), 1'b0, NO_WANT});
    dir_rows.push_back('{mk_beat(OP_LOOKUP, 48'hFFFF_FFFF_FFFE, '0, '0, '0, '0), 1'b0, NO_WANT});

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_op(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);

    // Random phases: add-heavy ones fill the table, remove-heavy ones drain it.
    items_sent = 0;
    phase      = 0;
    while (items_sent < RAND_ITEMS) begin
      kind    = (phase < 3) ? phase : $urandom_range(0, 2);
      idle_on = (phase != 3);
      foreach (base_pool[i]) base_pool[i] = ADDR_W'({$urandom(), $urandom()});
      phase_len = $urandom_range(100, 200);
      for (int n = 0; n < phase_len && items_sent < RAND_ITEMS; n++) begin
        b.opcode     = OP_LOOKUP;
        b.address    = ADDR_W'({$urandom(), $urandom()});
        b.prefix_len = PLEN_W'($urandom());
        b.metric     = COST_W'($urandom());
        b.iface      = PORT_W'($urandom());
        b.next_hop   = HOP_W'({$urandom(), $urandom()});
        rnd48        = ADDR_W'({$urandom(), $urandom()});
        r            = $urandom_range(0, 99);
        if (r < ((kind == 0) ? 60 : (kind == 1) ? 15 : 35)) begin
          // Route add with clustered destinations so that keys collide.
          b.opcode = OP_ADD;
          pick     = $urandom_range(0, 15);
          if (pick == 0) b.prefix_len = '0;
          else if (pick == 1) b.prefix_len = PLEN_W'($urandom_range(49, 63));
          else if (pick == 2) b.prefix_len = PLEN_W'(ADDR_W);
          else b.prefix_len = PLEN_W'($urandom_range(1, 47));
          b.address = base_pool[$urandom_range(0, 7)];
          if ($urandom_range(0, 1) == 1) b.address ^= rnd48 >> $urandom_range(0, ADDR_W);
          if ($urandom_range(0, 1) == 1) b.metric = COST_W'($urandom_range(0, 3));
        end else if (r < ((kind == 0) ? 70 : 65)) begin
          // Route remove: mostly a held route, otherwise a near miss or noise.
          b.opcode = OP_REMOVE;
          if (route_cnt > 0 && $urandom_range(0, 9) < 8) begin
            sel          = routes[$urandom_range(0, route_cnt - 1)];
            b.address    = sel.dest;
            b.prefix_len = sel.prefix;
            b.metric     = sel.cost;
            b.iface      = sel.port;
            b.next_hop   = sel.hop;
            if (sel.prefix == ADDR_W && $urandom_range(0, 3) == 0)
              b.prefix_len = PLEN_W'($urandom_range(49, 63));
            if ($urandom_range(0, 4) == 0) begin
              k = $urandom_range(0, 3);
              case (k)
                0: b.address  ^= ADDR_W'(1) << $urandom_range(0, ADDR_W - 1);
                1: b.metric   ^= COST_W'(1) << $urandom_range(0, COST_W - 1);
                2: b.iface    ^= PORT_W'(1) << $urandom_range(0, PORT_W - 1);
                default: b.next_hop ^= HOP_W'(1) << $urandom_range(0, HOP_W - 1);
              endcase
            end
          end
        end else if (r < 97) begin
          // Lookup, mostly inside the prefix of a held route.
          if (route_cnt > 0 && $urandom_range(0, 3) != 0) begin
            sel       = routes[$urandom_range(0, route_cnt - 1)];
            b.address = sel.dest ^ (rnd48 >> sel.prefix);
          end
        end else begin
          b.opcode = OP_UNUSED;
        end
        send_op(b, 1'b0, NO_WANT);
        items_sent++;
      end
      // Hold the request side until every response of the phase is back.
      while (pending_results.size() != 0) begin
        req_if.valid <= 1'b0;
        @(posedge clk_i);
      end
      phase++;
    end

    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);

    $write("Ran %0d beats over %0d random phases: ",
           n_lookup + n_add + n_remove + n_unused, phase);
    $display("%0d lookups (%0d hits), %0d adds (%0d refused full),",
             n_lookup, n_hit, n_add, n_full);
    $display("%0d removes (%0d found), %0d undefined opcodes, peak of %0d routes, %0d mismatches.",
             n_remove, n_removed, n_unused, peak_cnt, mismatch_cnt);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
rtl/srtlpm_pkg.sv
rtl/srtlpm_if.sv
rtl/srtlpm_cell.sv
rtl/srtlpm_scan.sv
rtl/sorted_route_table_lpm_unit.sv
tb/sv/tb_top.sv
